// ----- rtl/assert_macros.svh -----
// Assertion helpers, clocked on clock, reset is active high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FK6_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FK6_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FK6_ASSERT(lbl, prop, msg)
`define FK6_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ----- rtl/fk6_pkg.sv -----
`timescale 1ns / 1ps
package fk6_pkg;

   localparam int TRIG_ITERATIONS_DEF = 24;
   localparam int ROT_FRAC_BITS_DEF   = 30;

   localparam int JOINTS       = 6;
   localparam int ANGLE_W      = 20;
   localparam int LANE_ANGLE_W = 21;
   localparam int LEN_W        = 21;
   localparam int D_W          = 22;
   localparam int LV_W         = 23;
   localparam int POS_ACC_W    = 28;
   localparam int ROT_OUT_W    = 32;
   localparam int POS_OUT_W    = 25;
   localparam int CSR_IDX_W    = 3;

   localparam int TURN_UNITS      = 368640;
   localparam int HALF_UNITS      = 184320;
   localparam int QUARTER_UNITS   = 92160;
   localparam int CORDIC_GAIN_Q30 = 652032874;
   localparam int POS_LIMIT       = 12000000;
   localparam logic signed [31:0] DEG_TO_RAD_Q46 = 32'sd1199381129;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_BASE_HEIGHT      = 3'd0;
   localparam csr_idx_type REG_SHOULDER_OFFSET  = 3'd1;
   localparam csr_idx_type REG_UPPER_ARM_LENGTH = 3'd2;
   localparam csr_idx_type REG_ELBOW_OFFSET     = 3'd3;
   localparam csr_idx_type REG_FOREARM_LENGTH   = 3'd4;
   localparam csr_idx_type REG_TOOL_LENGTH      = 3'd5;

   typedef logic [2:0] joint_idx_type;
   localparam joint_idx_type JOINT_ONE   = 3'd0;
   localparam joint_idx_type JOINT_TWO   = 3'd1;
   localparam joint_idx_type JOINT_THREE = 3'd2;
   localparam joint_idx_type JOINT_FOUR  = 3'd3;
   localparam joint_idx_type JOINT_FIVE  = 3'd4;
   localparam joint_idx_type JOINT_SIX   = 3'd5;

   typedef struct packed {
      logic [LEN_W-1:0] base_height;
      logic [LEN_W-1:0] shoulder_offset;
      logic [LEN_W-1:0] upper_arm_length;
      logic [LEN_W-1:0] elbow_offset;
      logic [LEN_W-1:0] forearm_length;
      logic [LEN_W-1:0] tool_length;
   } link_cfg_type;

   typedef enum logic [1:0] {
      LANE_IDLE, LANE_SCALE, LANE_ROTATE, LANE_DONE
   } lane_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lane_status_type;

   typedef enum logic [1:0] {
      CH_IDLE, CH_RUN, CH_DONE
   } chain_state_type;

   typedef struct packed {
      logic idle;
      logic done;
   } chain_status_type;

   typedef enum logic [3:0] {
      ST_LV_MUL, ST_LV_RND, ST_P0, ST_P1, ST_P2, ST_P3, ST_RA, ST_RB, ST_RC, ST_RD
   } chain_step_type;

   // atan(2^-i) in Q30
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      case (idx)
         5'd0:  return 32'h3243F6A8;
         5'd1:  return 32'h1DAC6705;
         5'd2:  return 32'h0FADBAFC;
         5'd3:  return 32'h07F56EA6;
         5'd4:  return 32'h03FEAB76;
         5'd5:  return 32'h01FFD55B;
         5'd6:  return 32'h00FFFAAA;
         5'd7:  return 32'h007FFF55;
         5'd8:  return 32'h003FFFEA;
         5'd9:  return 32'h001FFFFD;
         5'd10: return 32'h000FFFFF;
         5'd11: return 32'h0007FFFF;
         5'd12: return 32'h0003FFFF;
         5'd13: return 32'h0001FFFF;
         5'd14: return 32'h0000FFFF;
         5'd15: return 32'h00007FFF;
         5'd16: return 32'h00003FFF;
         5'd17: return 32'h00001FFF;
         5'd18: return 32'h00000FFF;
         5'd19: return 32'h000007FF;
         5'd20: return 32'h000003FF;
         5'd21: return 32'h000001FF;
         5'd22: return 32'h000000FF;
         5'd23: return 32'h0000007F;
         5'd24: return 32'h0000003F;
         5'd25: return 32'h0000001F;
         5'd26: return 32'h0000000F;
         5'd27: return 32'h00000007;
         5'd28: return 32'h00000003;
         5'd29: return 32'h00000001;
         default: return 32'h00000000;
      endcase
   endfunction

endpackage

// ----- rtl/fk6_ifs.sv -----
`timescale 1ns / 1ps
interface fk6_req_if
   import fk6_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle_one;
   logic signed [ANGLE_W-1:0] angle_two;
   logic signed [ANGLE_W-1:0] angle_three;
   logic signed [ANGLE_W-1:0] angle_four;
   logic signed [ANGLE_W-1:0] angle_five;
   logic signed [ANGLE_W-1:0] angle_six;

   modport source (output valid, angle_one, angle_two, angle_three, angle_four,
                   angle_five, angle_six, input ready);
   modport sink (input valid, angle_one, angle_two, angle_three, angle_four,
                 angle_five, angle_six, output ready);
endinterface

interface fk6_rsp_if
   import fk6_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic signed [ROT_OUT_W-1:0] rot_xx;
   logic signed [ROT_OUT_W-1:0] rot_yx;
   logic signed [ROT_OUT_W-1:0] rot_zx;
   logic signed [ROT_OUT_W-1:0] rot_xy;
   logic signed [ROT_OUT_W-1:0] rot_yy;
   logic signed [ROT_OUT_W-1:0] rot_zy;
   logic signed [ROT_OUT_W-1:0] rot_xz;
   logic signed [ROT_OUT_W-1:0] rot_yz;
   logic signed [ROT_OUT_W-1:0] rot_zz;
   logic signed [POS_OUT_W-1:0] pos_x;
   logic signed [POS_OUT_W-1:0] pos_y;
   logic signed [POS_OUT_W-1:0] pos_z;

   modport source (output valid, rot_xx, rot_yx, rot_zx, rot_xy, rot_yy, rot_zy,
                   rot_xz, rot_yz, rot_zz, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, rot_xx, rot_yx, rot_zx, rot_xy, rot_yy, rot_zy,
                 rot_xz, rot_yz, rot_zz, pos_x, pos_y, pos_z, output ready);
endinterface

interface fk6_csr_if
   import fk6_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [LEN_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/fk6_lane.sv -----
`timescale 1ns / 1ps
// One joint: angle reduction, degree to radian scaling, iterative CORDIC.
module fk6_lane
   import fk6_pkg::*;
#(
   parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF,
   parameter int ROT_FRAC_BITS   = ROT_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           drain,
   input  logic signed [LANE_ANGLE_W-1:0] angle,
   output lane_status_type                status,
   output logic signed [ROT_FRAC_BITS+1:0] sin_out,
   output logic signed [ROT_FRAC_BITS+1:0] cos_out
);

   localparam int RW    = ROT_FRAC_BITS + 2;
   localparam int ITERS = (TRIG_ITERATIONS < 32) ? TRIG_ITERATIONS : 32;
   localparam int CW    = 34;
   localparam int SH    = 30 - ROT_FRAC_BITS;
   localparam int RED_W = 22;
   localparam int R_W   = 18;
   localparam int IT_W  = 6;
   localparam int PR_W  = 50;
   localparam logic signed [CW-1:0] RND  = CW'((64'(1) << SH) >> 1);
   localparam logic signed [CW-1:0] ONE  = CW'(64'(1) << ROT_FRAC_BITS);
   localparam logic signed [CW-1:0] GAIN = CW'(CORDIC_GAIN_Q30);
   localparam logic signed [RED_W-1:0] TURN    = RED_W'(TURN_UNITS);
   localparam logic signed [RED_W-1:0] HALF    = RED_W'(HALF_UNITS);
   localparam logic signed [RED_W-1:0] QUARTER = RED_W'(QUARTER_UNITS);
   localparam logic signed [PR_W-1:0]  PR_RND  = PR_W'(32768);

   lane_state_type state_ff, state_in;
   logic signed [R_W-1:0] r_ff;
   logic                  neg_ff;
   logic signed [CW-1:0]  x_ff, y_ff, z_ff;
   logic [IT_W-1:0]       iter_ff;

   logic signed [RED_W-1:0] a0, a1, a2, a3, a4;
   logic signed [R_W-1:0]   r_red;
   logic                    neg_red;
   logic signed [PR_W-1:0]  prod;
   logic signed [CW-1:0]    z_scaled;
   logic [4:0]              idx;
   logic signed [CW-1:0]    xs, ys, at;
   logic signed [CW-1:0]    xr, yr;

   // reduce to [-90, 90] degrees, remember the half turn
   always_comb begin
      a0 = RED_W'(angle);
      a1 = (a0 < 0) ? a0 + TURN : a0;
      a2 = (a1 < 0) ? a1 + TURN : a1;
      a3 = (a2 >= TURN) ? a2 - TURN : a2;
      a4 = (a3 >= HALF) ? a3 - TURN : a3;
      if (a4 > QUARTER) begin
         r_red   = R_W'(a4 - HALF);
         neg_red = 1'b1;
      end else if (a4 < -QUARTER) begin
         r_red   = R_W'(a4 + HALF);
         neg_red = 1'b1;
      end else begin
         r_red   = R_W'(a4);
         neg_red = 1'b0;
      end
   end

   assign prod     = PR_W'(r_ff) * PR_W'(DEG_TO_RAD_Q46);
   assign z_scaled = CW'((prod + PR_RND) >>> 16);

   assign idx = iter_ff[4:0];
   assign xs  = x_ff >>> idx;
   assign ys  = y_ff >>> idx;
   assign at  = $signed({{(CW-32){1'b0}}, atan_q30(idx)});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         LANE_IDLE: begin
            r_ff   <= r_red;
            neg_ff <= neg_red;
         end
         LANE_SCALE: begin
            x_ff    <= GAIN;
            y_ff    <= '0;
            z_ff    <= z_scaled;
            iter_ff <= '0;
         end
         LANE_ROTATE: begin
            if (!z_ff[CW-1]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end
            iter_ff <= iter_ff + IT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LANE_IDLE:   if (start) state_in = LANE_SCALE;
         LANE_SCALE:  state_in = LANE_ROTATE;
         LANE_ROTATE: if (iter_ff == IT_W'(ITERS - 1)) state_in = LANE_DONE;
         LANE_DONE:   if (drain) state_in = LANE_IDLE;
         default:     state_in = LANE_IDLE;
      endcase
   end

   always_comb begin
      status.busy = (state_ff != LANE_IDLE);
      status.done = (state_ff == LANE_DONE);
   end

   // round to the output fraction, undo the half turn, clamp to +-1
   always_comb begin
      xr = (x_ff + RND) >>> SH;
      yr = (y_ff + RND) >>> SH;
      if (neg_ff) begin
         xr = -xr;
         yr = -yr;
      end
      if (xr > ONE) xr = ONE;
      else if (xr < -ONE) xr = -ONE;
      if (yr > ONE) yr = ONE;
      else if (yr < -ONE) yr = -ONE;
      cos_out = RW'(xr);
      sin_out = RW'(yr);
   end

endmodule

// ----- rtl/fk6_chain.sv -----
`timescale 1ns / 1ps
// Merges the lane results: six DH transforms applied in order, one
// multiplier per matrix row, ten steps per joint.
module fk6_chain
   import fk6_pkg::*;
#(
   parameter int ROT_FRAC_BITS = ROT_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic                            take,
   input  logic signed [ROT_FRAC_BITS+1:0] sin_in [JOINTS],
   input  logic signed [ROT_FRAC_BITS+1:0] cos_in [JOINTS],
   input  link_cfg_type                    cfg,
   output chain_status_type                status,
   output logic signed [ROT_OUT_W-1:0]     rot_out [3][3],
   output logic signed [POS_OUT_W-1:0]     pos_out [3]
);

   localparam int F  = ROT_FRAC_BITS;
   localparam int RW = F + 2;
   localparam int BW = (RW > LV_W) ? RW : LV_W;
   localparam int PW = RW + BW;
   localparam int AW = PW + 2;
   localparam int SHL = 30 - F;
   localparam logic signed [AW-1:0] ONE_A = AW'(1) << F;
   localparam logic signed [AW-1:0] RND_A = AW'(1) << (F - 1);
   localparam logic signed [RW-1:0] ONE_R = RW'(1) << F;
   localparam logic signed [1:0] TW_POS  = 2'sb01;
   localparam logic signed [1:0] TW_NEG  = 2'sb11;
   localparam logic signed [1:0] TW_ZERO = 2'sb00;
   localparam logic signed [POS_ACC_W-1:0] POS_LIM = POS_ACC_W'(POS_LIMIT);

   chain_state_type state_ff, state_in;
   chain_step_type  step_ff;
   joint_idx_type   joint_ff;
   logic signed [RW-1:0]        rot_ff [3][3];
   logic signed [RW-1:0]        nr0_ff [3];
   logic signed [POS_ACC_W-1:0] pos_ff [3];
   logic signed [RW-1:0]        sn_ff [JOINTS];
   logic signed [RW-1:0]        cs_ff [JOINTS];
   logic signed [LV_W-1:0]      lv0_ff, lv1_ff;
   logic signed [PW-1:0]        p_ff [3];
   logic signed [AW-1:0]        acc_ff [3];

   logic signed [RW-1:0]  sn_j, cs_j;
   logic [LEN_W-1:0]      a_j;
   logic signed [D_W-1:0] d_j;
   logic signed [1:0]     ca_j, sa_j;
   logic signed [RW-1:0]  op_a [3];
   logic signed [BW-1:0]  op_b [3];
   logic signed [PW-1:0]  prod [3];
   logic signed [AW-1:0]  s_sum [3];
   logic signed [AW-1:0]  w_dif [3];
   logic signed [AW-1:0]  r2s [3];
   logic signed [AW-1:0]  col1 [3];
   logic signed [AW-1:0]  col2 [3];
   logic                  last_step;

   function automatic logic signed [AW-1:0] rnd(input logic signed [AW-1:0] v);
      return (v + RND_A) >>> F;
   endfunction

   function automatic logic signed [RW-1:0] clamp_rot(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] c;
      c = v;
      if (v > ONE_A) c = ONE_A;
      else if (v < -ONE_A) c = -ONE_A;
      return RW'(c);
   endfunction

   function automatic logic signed [AW-1:0] sgn_mul(input logic signed [AW-1:0] v,
                                                    input logic signed [1:0] s);
      case (s)
         TW_POS:  return v;
         TW_NEG:  return -v;
         default: return '0;
      endcase
   endfunction

   assign sn_j = sn_ff[joint_ff];
   assign cs_j = cs_ff[joint_ff];

   // link lengths and twist per joint
   always_comb begin
      a_j  = '0;
      d_j  = '0;
      ca_j = TW_ZERO;
      sa_j = TW_ZERO;
      unique case (joint_ff)
         JOINT_ONE: begin
            a_j  = cfg.shoulder_offset;
            d_j  = $signed({1'b0, cfg.base_height});
            sa_j = TW_NEG;
         end
         JOINT_TWO: begin
            a_j  = cfg.upper_arm_length;
            ca_j = TW_POS;
         end
         JOINT_THREE: begin
            a_j  = cfg.elbow_offset;
            sa_j = TW_POS;
         end
         JOINT_FOUR: begin
            d_j  = -$signed({1'b0, cfg.forearm_length});
            sa_j = TW_NEG;
         end
         JOINT_FIVE: sa_j = TW_POS;
         JOINT_SIX: begin
            d_j  = -$signed({1'b0, cfg.tool_length});
            ca_j = TW_NEG;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         op_a[r] = '0;
         op_b[r] = '0;
      end
      case (step_ff)
         ST_LV_MUL: begin
            op_a[0] = cs_j;
            op_a[1] = sn_j;
            op_b[0] = BW'($signed({1'b0, a_j}));
            op_b[1] = BW'($signed({1'b0, a_j}));
         end
         ST_P0: for (int r = 0; r < 3; r++) begin
            op_a[r] = rot_ff[r][0];
            op_b[r] = BW'(lv0_ff);
         end
         ST_P1: for (int r = 0; r < 3; r++) begin
            op_a[r] = rot_ff[r][1];
            op_b[r] = BW'(lv1_ff);
         end
         ST_P2: for (int r = 0; r < 3; r++) begin
            op_a[r] = rot_ff[r][2];
            op_b[r] = BW'(d_j);
         end
         ST_P3: for (int r = 0; r < 3; r++) begin
            op_a[r] = rot_ff[r][0];
            op_b[r] = BW'(cs_j);
         end
         ST_RA: for (int r = 0; r < 3; r++) begin
            op_a[r] = rot_ff[r][1];
            op_b[r] = BW'(sn_j);
         end
         ST_RB: for (int r = 0; r < 3; r++) begin
            op_a[r] = rot_ff[r][0];
            op_b[r] = BW'(sn_j);
         end
         ST_RC: for (int r = 0; r < 3; r++) begin
            op_a[r] = rot_ff[r][1];
            op_b[r] = BW'(cs_j);
         end
         default: begin
         end
      endcase
   end

   // col0 = R0*c + R1*s; w = R0*s - R1*c feeds columns one and two
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod[r]  = PW'(op_a[r]) * PW'(op_b[r]);
         s_sum[r] = acc_ff[r] + AW'(p_ff[r]);
         w_dif[r] = acc_ff[r] - AW'(p_ff[r]);
         r2s[r]   = AW'(rot_ff[r][2]) <<< F;
         col1[r]  = sgn_mul(-w_dif[r], ca_j) + sgn_mul(r2s[r], sa_j);
         col2[r]  = sgn_mul(w_dif[r], sa_j) + sgn_mul(r2s[r], ca_j);
      end
   end

   assign last_step = (step_ff == ST_RD) && (joint_ff == JOINT_SIX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CH_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         p_ff[r] <= prod[r];
      end
      if (state_ff == CH_IDLE) begin
         step_ff  <= ST_LV_MUL;
         joint_ff <= JOINT_ONE;
         for (int r = 0; r < 3; r++) begin
            pos_ff[r] <= '0;
            for (int c = 0; c < 3; c++) begin
               rot_ff[r][c] <= (r == c) ? ONE_R : '0;
            end
         end
         for (int j = 0; j < JOINTS; j++) begin
            sn_ff[j] <= sin_in[j];
            cs_ff[j] <= cos_in[j];
         end
      end else if (state_ff == CH_RUN) begin
         if (step_ff == ST_RD) begin
            step_ff  <= ST_LV_MUL;
            joint_ff <= joint_ff + 3'd1;
         end else begin
            step_ff <= chain_step_type'(step_ff + 4'd1);
         end
         case (step_ff)
            ST_LV_RND: begin
               lv0_ff <= LV_W'(rnd(AW'(p_ff[0])));
               lv1_ff <= LV_W'(rnd(AW'(p_ff[1])));
            end
            ST_P1, ST_RA, ST_RC: for (int r = 0; r < 3; r++) begin
               acc_ff[r] <= AW'(p_ff[r]);
            end
            ST_P2: for (int r = 0; r < 3; r++) begin
               acc_ff[r] <= s_sum[r];
            end
            ST_P3: for (int r = 0; r < 3; r++) begin
               pos_ff[r] <= pos_ff[r] + POS_ACC_W'(rnd(s_sum[r]));
            end
            ST_RB: for (int r = 0; r < 3; r++) begin
               nr0_ff[r] <= clamp_rot(rnd(s_sum[r]));
            end
            ST_RD: for (int r = 0; r < 3; r++) begin
               rot_ff[r][0] <= nr0_ff[r];
               rot_ff[r][1] <= clamp_rot(rnd(col1[r]));
               rot_ff[r][2] <= clamp_rot(rnd(col2[r]));
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CH_IDLE: if (load) state_in = CH_RUN;
         CH_RUN:  if (last_step) state_in = CH_DONE;
         CH_DONE: if (take) state_in = CH_IDLE;
         default: state_in = CH_IDLE;
      endcase
   end

   always_comb begin
      status.idle = (state_ff == CH_IDLE);
      status.done = (state_ff == CH_DONE);
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            rot_out[r][c] = ROT_OUT_W'(rot_ff[r][c]) <<< SHL;
         end
         if (pos_ff[r] > POS_LIM) pos_out[r] = POS_OUT_W'(POS_LIM);
         else if (pos_ff[r] < -POS_LIM) pos_out[r] = POS_OUT_W'(-POS_LIM);
         else pos_out[r] = POS_OUT_W'(pos_ff[r]);
      end
   end

endmodule

// ----- rtl/arm_forward_kinematics_6axis.sv -----
`timescale 1ns / 1ps
// Lanes take the next item while the merge chain (6 joints x 10 steps on one
// multiplier per row) works on the last one; the chain holds its result until
// the output register is free, and back-pressure on rsp stalls it there.
// Reset: synchronous, active high; clears lanes, chain, output valid and the
// link registers (all zero). No clearing pass.
`include "assert_macros.svh"
module arm_forward_kinematics_6axis
   import fk6_pkg::*;
#(
   parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF,
   parameter int ROT_FRAC_BITS   = ROT_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fk6_req_if.sink   req_if,
   fk6_rsp_if.source rsp_if,
   fk6_csr_if.sink   csr_if
);

   localparam int RW = ROT_FRAC_BITS + 2;
   localparam logic signed [POS_OUT_W-1:0] POS_MAX = POS_OUT_W'(POS_LIMIT);
   localparam logic signed [ROT_OUT_W-1:0] ROT_MAX = ROT_OUT_W'(1 << 30);

   // link lengths
   link_cfg_type link_cfg_ff;

   // lanes
   logic signed [LANE_ANGLE_W-1:0] lane_angle [JOINTS];
   lane_status_type                lane_status [JOINTS];
   logic signed [RW-1:0]           lane_sin [JOINTS];
   logic signed [RW-1:0]           lane_cos [JOINTS];
   logic [JOINTS-1:0]              lane_busy_vec, lane_done_vec;
   logic                           accept, handoff;

   // chain and output register
   chain_status_type            chain_status;
   logic signed [ROT_OUT_W-1:0] chain_rot [3][3];
   logic signed [POS_OUT_W-1:0] chain_pos [3];
   logic                        out_take;
   logic                        rsp_valid_ff;
   logic signed [ROT_OUT_W-1:0] rsp_rot_ff [3][3];
   logic signed [POS_OUT_W-1:0] rsp_pos_ff [3];

   // range flags for the checks below
   logic                        pos_x_ok, rot_xx_ok;

   // register writes; indexes past the list are dropped
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_cfg_ff <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_BASE_HEIGHT:      link_cfg_ff.base_height      <= csr_if.data;
            REG_SHOULDER_OFFSET:  link_cfg_ff.shoulder_offset  <= csr_if.data;
            REG_UPPER_ARM_LENGTH: link_cfg_ff.upper_arm_length <= csr_if.data;
            REG_ELBOW_OFFSET:     link_cfg_ff.elbow_offset     <= csr_if.data;
            REG_FOREARM_LENGTH:   link_cfg_ff.forearm_length   <= csr_if.data;
            REG_TOOL_LENGTH:      link_cfg_ff.tool_length      <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   // joint three carries a -90 degree offset
   assign lane_angle[0] = LANE_ANGLE_W'(req_if.angle_one);
   assign lane_angle[1] = LANE_ANGLE_W'(req_if.angle_two);
   assign lane_angle[2] = LANE_ANGLE_W'(req_if.angle_three) -
                          LANE_ANGLE_W'(QUARTER_UNITS);
   assign lane_angle[3] = LANE_ANGLE_W'(req_if.angle_four);
   assign lane_angle[4] = LANE_ANGLE_W'(req_if.angle_five);
   assign lane_angle[5] = LANE_ANGLE_W'(req_if.angle_six);

   always_comb begin
      for (int j = 0; j < JOINTS; j++) begin
         lane_busy_vec[j] = lane_status[j].busy;
         lane_done_vec[j] = lane_status[j].done;
      end
   end

   // lanes take a new item once the chain has taken their last one
   assign req_if.ready = !(|lane_busy_vec);
   assign accept       = req_if.valid && req_if.ready;
   assign handoff      = (&lane_done_vec) && chain_status.idle;

   for (genvar j = 0; j < JOINTS; j++) begin : g_lane
      fk6_lane #(
         .TRIG_ITERATIONS (TRIG_ITERATIONS),
         .ROT_FRAC_BITS   (ROT_FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (accept),
         .drain   (handoff),
         .angle   (lane_angle[j]),
         .status  (lane_status[j]),
         .sin_out (lane_sin[j]),
         .cos_out (lane_cos[j])
      );
   end

   fk6_chain #(
      .ROT_FRAC_BITS (ROT_FRAC_BITS)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .load    (handoff),
      .take    (out_take),
      .sin_in  (lane_sin),
      .cos_in  (lane_cos),
      .cfg     (link_cfg_ff),
      .status  (chain_status),
      .rot_out (chain_rot),
      .pos_out (chain_pos)
   );

   // output register: a finished chain waits in its done state until the last pose is taken
   assign out_take = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= chain_status.done;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take && chain_status.done) begin
         rsp_rot_ff <= chain_rot;
         rsp_pos_ff <= chain_pos;
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.rot_xx = rsp_rot_ff[0][0];
   assign rsp_if.rot_yx = rsp_rot_ff[1][0];
   assign rsp_if.rot_zx = rsp_rot_ff[2][0];
   assign rsp_if.rot_xy = rsp_rot_ff[0][1];
   assign rsp_if.rot_yy = rsp_rot_ff[1][1];
   assign rsp_if.rot_zy = rsp_rot_ff[2][1];
   assign rsp_if.rot_xz = rsp_rot_ff[0][2];
   assign rsp_if.rot_yz = rsp_rot_ff[1][2];
   assign rsp_if.rot_zz = rsp_rot_ff[2][2];
   assign rsp_if.pos_x  = rsp_pos_ff[0];
   assign rsp_if.pos_y  = rsp_pos_ff[1];
   assign rsp_if.pos_z  = rsp_pos_ff[2];

   assign pos_x_ok  = (rsp_pos_ff[0] <= POS_MAX) && (rsp_pos_ff[0] >= -POS_MAX);
   assign rot_xx_ok = (rsp_rot_ff[0][0] <= ROT_MAX) && (rsp_rot_ff[0][0] >= -ROT_MAX);

   `FK6_ASSERT(a_lanes_start, accept |=> (&lane_busy_vec), "lanes did not start together")
   `FK6_ASSERT(a_handoff_frees, handoff |=> !(|lane_busy_vec), "lanes not freed by handoff")
   `FK6_ASSERT(a_pos_range, rsp_valid_ff |-> pos_x_ok, "pos_x out of range")
   `FK6_ASSERT(a_rot_range, rsp_valid_ff |-> rot_xx_ok, "rot_xx out of range")
   `FK6_ASSERT_NR(a_reset_clears, reset |=> !rsp_valid_ff && !(|lane_busy_vec), "reset left state")

endmodule
